// File: rtl/lrip_pkg.sv
// Package with the transfer types, status codes and the arctangent table of the range image placer.
`default_nettype none
package lrip_pkg;

  // One input item.
  typedef struct packed {
    logic              action;
    logic signed [23:0] pos_x;
    logic signed [23:0] pos_y;
    logic              missing;
  } in_item_t;

  // One result item.
  typedef struct packed {
    logic [5:0]  row;
    logic [10:0] column;
    logic [16:0] point_number;
    logic [2:0]  status;
  } out_item_t;

  // Placement status codes.
  localparam logic [2:0] ST_OWN       = 3'd0;
  localparam logic [2:0] ST_RIGHT     = 3'd1;
  localparam logic [2:0] ST_LEFT      = 3'd2;
  localparam logic [2:0] ST_OVERWROTE = 3'd3;
  localparam logic [2:0] ST_MISSING   = 3'd4;
  localparam logic [2:0] ST_EXHAUSTED = 3'd5;
  localparam logic [2:0] ST_CLEARED   = 3'd6;

  // Register indexes on the configuration port.
  localparam logic REG_SHIFT     = 1'b0;
  localparam logic REG_THRESHOLD = 1'b1;

  // CORDIC datapath.
  localparam int CORDIC_STEPS = 24;
  localparam int CORDIC_XW    = 51;

  // Occupancy words: 64 cells per memory word.
  localparam int WORD_BITS = 64;

  // Arctangent of 2^-i as a 32-bit fraction of a full turn.
  function automatic logic [31:0] atan_turn(input logic [4:0] i);
    logic [31:0] r;
    case (i)
      5'd0:  r = 32'h20000000;
      5'd1:  r = 32'h12E4051E;
      5'd2:  r = 32'h09FB385B;
      5'd3:  r = 32'h051111D4;
      5'd4:  r = 32'h028B0D43;
      5'd5:  r = 32'h0145D7E1;
      5'd6:  r = 32'h00A2F61E;
      5'd7:  r = 32'h00517C55;
      5'd8:  r = 32'h0028BE53;
      5'd9:  r = 32'h00145F2F;
      5'd10: r = 32'h000A2F98;
      5'd11: r = 32'h000517CC;
      5'd12: r = 32'h00028BE6;
      5'd13: r = 32'h000145F3;
      5'd14: r = 32'h0000A2FA;
      5'd15: r = 32'h0000517D;
      5'd16: r = 32'h000028BE;
      5'd17: r = 32'h0000145F;
      5'd18: r = 32'h00000A30;
      5'd19: r = 32'h00000518;
      5'd20: r = 32'h0000028C;
      5'd21: r = 32'h00000146;
      5'd22: r = 32'h000000A3;
      5'd23: r = 32'h00000051;
      default: r = 32'h0;
    endcase
    return r;
  endfunction

endpackage
`default_nettype wire

// File: rtl/lidar_range_image_placer.sv
// Top level of the lidar range image placer: row tracking, column mapping and occupancy update.
// A point goes from its input transfer through the CORDIC, which runs up to its 24 steps, then
// the row step, three occupancy word reads, the write-back and the result load, which waits
// while a stalled result is held. A missing point, or one after the last row, goes straight
// to the result load. After reset and after every frame start the map is cleared one word
// per cycle, all IMAGE_ROWS * ceil(IMAGE_COLUMNS/64) words, with no input taken.
`default_nettype none
module lidar_range_image_placer #(
  parameter int IMAGE_ROWS    = 64,
  parameter int IMAGE_COLUMNS = 2048,
  parameter int ANGLE_BITS    = 16
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                in_valid,
  output logic                     in_stall,
  input  wire lrip_pkg::in_item_t  in_data,
  output logic                     out_valid,
  input  wire logic                out_stall,
  output lrip_pkg::out_item_t      out_data,
  input  wire logic                psel,
  input  wire logic                penable,
  input  wire logic                pwrite,
  input  wire logic [2:0]          paddr,
  input  wire logic [31:0]         pwdata,
  output logic [31:0]              prdata,
  output logic                     pready
);

  localparam int WB    = lrip_pkg::WORD_BITS;
  localparam int RW    = $clog2(IMAGE_ROWS + 1);
  localparam int CW    = $clog2(IMAGE_COLUMNS);
  localparam int WPR   = (IMAGE_COLUMNS + WB - 1) / WB;
  localparam int DEPTH = IMAGE_ROWS * WPR;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int PW    = ANGLE_BITS + CW + 1;
  localparam logic [ANGLE_BITS-1:0] HALF_TURN = ANGLE_BITS'(1) << (ANGLE_BITS - 1);
  localparam logic [CW:0]           LAST_COL  = (CW + 1)'(IMAGE_COLUMNS - 1);

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_ANGLE, S_PLACE, S_RD0, S_RD1, S_RD2, S_RD3, S_DECIDE, S_EMIT
  } state_t;

  state_t                state;
  logic                  shift_cfg;
  logic [15:0]           thr_cfg;
  logic [ANGLE_BITS-1:0] prev_angle;
  logic                  have_prev;
  logic [RW-1:0]         cur_row;
  logic [16:0]           counter;
  logic [16:0]           number;
  logic [ANGLE_BITS-1:0] u;
  logic [RW-1:0]         res_row;
  logic [CW-1:0]         res_col;
  logic [2:0]            res_status;
  logic                  go_clear;
  logic [AW-1:0]         clr_addr;
  logic [WB-1:0]         word_l;
  logic [WB-1:0]         word_c;
  logic [WB-1:0]         word_r;

  logic                  accept;
  logic                  cordic_start;
  logic                  cordic_done;
  logic [ANGLE_BITS-1:0] cordic_angle;
  logic                  emit_load;

  // Configuration port: always ready, reads return the register.
  assign pready = 1'b1;
  always_comb begin
    unique case (paddr[2])
      lrip_pkg::REG_SHIFT:     prdata = {31'd0, shift_cfg};
      lrip_pkg::REG_THRESHOLD: prdata = {16'd0, thr_cfg};
      default:                 prdata = 32'd0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      shift_cfg <= 1'b1;
      thr_cfg   <= 16'd7301;
    end else if (psel && penable && pwrite && pready) begin
      unique case (paddr[2])
        lrip_pkg::REG_SHIFT:     shift_cfg <= pwdata[0];
        lrip_pkg::REG_THRESHOLD: thr_cfg   <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  // Input handshake: one item at a time.
  assign in_stall     = (state != S_IDLE);
  assign accept       = in_valid && !in_stall;
  assign cordic_start = accept && !in_data.action && !in_data.missing
                        && (cur_row < RW'(IMAGE_ROWS));

  lrip_cordic #(.ANGLE_BITS(ANGLE_BITS)) u_cordic (
    .clk   (clk),
    .rst   (rst),
    .start (cordic_start),
    .pos_x (in_data.pos_x),
    .pos_y (in_data.pos_y),
    .done  (cordic_done),
    .angle (cordic_angle)
  );

  // Row jump test and column mapping from the captured angle.
  logic [ANGLE_BITS-1:0]  diff;
  logic [ANGLE_BITS+15:0] jump_lhs;
  logic [ANGLE_BITS+15:0] jump_rhs;
  logic                   jump;
  logic [RW-1:0]          row_next;
  logic [ANGLE_BITS-1:0]  half_offset;
  logic [PW-1:0]          prod;
  logic [CW:0]            col_raw;
  logic [CW-1:0]          col_new;

  assign diff        = prev_angle - u;
  assign jump_lhs    = {diff, 16'd0};
  assign jump_rhs    = {thr_cfg, {ANGLE_BITS{1'b0}}};
  assign jump        = have_prev && (prev_angle > u) && (jump_lhs > jump_rhs);
  assign row_next    = cur_row + RW'(jump);
  assign half_offset = HALF_TURN - u;
  assign prod        = PW'(half_offset) * PW'(IMAGE_COLUMNS);
  assign col_raw     = (CW + 1)'(prod >> ANGLE_BITS);
  assign col_new     = (col_raw > LAST_COL) ? CW'(LAST_COL) : CW'(col_raw);

  // Neighbor columns and their word addresses.
  logic          has_right;
  logic          has_left;
  logic [CW-1:0] col_l;
  logic [CW-1:0] col_r;
  logic [AW-1:0] row_base;

  assign has_right = (CW + 1)'(res_col) < LAST_COL;
  assign has_left  = (res_col != '0);
  assign col_r     = has_right ? res_col + CW'(1) : res_col;
  assign col_l     = has_left  ? res_col - CW'(1) : res_col;
  assign row_base  = AW'(res_row * WPR);

  function automatic logic [AW-1:0] word_addr(input logic [AW-1:0] base,
                                               input logic [CW-1:0] c);
    return base + AW'(c / WB);
  endfunction

  // Placement decision over the three words.
  logic          own_taken;
  logic          right_free;
  logic          left_free;
  logic [2:0]    place_status;
  logic [CW-1:0] place_col;
  logic [WB-1:0] place_word;

  assign own_taken  = word_c[6'(res_col % WB)];
  assign right_free = has_right && !word_r[6'(col_r % WB)];
  assign left_free  = has_left && !word_l[6'(col_l % WB)];

  always_comb begin
    place_status = lrip_pkg::ST_OVERWROTE;
    place_col    = res_col;
    place_word   = word_c;
    if (!own_taken) begin
      place_status = lrip_pkg::ST_OWN;
    end else if (shift_cfg && right_free) begin
      place_status = lrip_pkg::ST_RIGHT;
      place_col    = col_r;
      place_word   = word_r;
    end else if (shift_cfg && left_free) begin
      place_status = lrip_pkg::ST_LEFT;
      place_col    = col_l;
      place_word   = word_l;
    end
  end

  // Map memory ports.
  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic [WB-1:0] ram_wdata;
  logic [AW-1:0] ram_raddr;
  logic [WB-1:0] ram_rdata;

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = clr_addr;
    ram_wdata = '0;
    if (state == S_CLEAR) begin
      ram_we = 1'b1;
    end else if (state == S_DECIDE) begin
      ram_we    = 1'b1;
      ram_waddr = word_addr(row_base, place_col);
      ram_wdata = place_word | (WB'(1) << (place_col % WB));
    end
  end

  always_comb begin
    case (state)
      S_RD0:   ram_raddr = word_addr(row_base, col_l);
      S_RD1:   ram_raddr = word_addr(row_base, res_col);
      default: ram_raddr = word_addr(row_base, col_r);
    endcase
  end

  lrip_ram #(.WIDTH(WB), .DEPTH(DEPTH)) u_map (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // In the emit state the result register loads when it is empty or being drained.
  assign emit_load = (state == S_EMIT) && (!out_valid || !out_stall);

  // Sequencer, frame state and result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_CLEAR;
      clr_addr   <= '0;
      go_clear   <= 1'b0;
      prev_angle <= '0;
      have_prev  <= 1'b0;
      cur_row    <= '0;
      counter    <= '0;
      out_valid  <= 1'b0;
    end else begin
      if (emit_load) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_CLEAR: begin
          if (clr_addr == AW'(DEPTH - 1)) begin
            clr_addr <= '0;
            state    <= S_IDLE;
          end else begin
            clr_addr <= clr_addr + AW'(1);
          end
        end
        S_IDLE: begin
          if (accept) begin
            res_row  <= '0;
            res_col  <= '0;
            go_clear <= in_data.action;
            if (in_data.action) begin
              number     <= '0;
              counter    <= '0;
              cur_row    <= '0;
              prev_angle <= '0;
              have_prev  <= 1'b0;
              res_status <= lrip_pkg::ST_CLEARED;
              state      <= S_EMIT;
            end else begin
              number  <= counter;
              counter <= counter + 17'd1;
              if (in_data.missing) begin
                have_prev  <= 1'b0;
                res_status <= lrip_pkg::ST_MISSING;
                state      <= S_EMIT;
              end else if (cur_row >= RW'(IMAGE_ROWS)) begin
                res_status <= lrip_pkg::ST_EXHAUSTED;
                state      <= S_EMIT;
              end else begin
                state <= S_ANGLE;
              end
            end
          end
        end
        S_ANGLE: begin
          if (cordic_done) begin
            u     <= cordic_angle;
            state <= S_PLACE;
          end
        end
        S_PLACE: begin
          cur_row    <= row_next;
          prev_angle <= u;
          have_prev  <= 1'b1;
          if (row_next >= RW'(IMAGE_ROWS)) begin
            res_status <= lrip_pkg::ST_EXHAUSTED;
            state      <= S_EMIT;
          end else begin
            res_row <= row_next;
            res_col <= col_new;
            state   <= S_RD0;
          end
        end
        S_RD0: state <= S_RD1;
        S_RD1: begin
          word_l <= ram_rdata;
          state  <= S_RD2;
        end
        S_RD2: begin
          word_c <= ram_rdata;
          state  <= S_RD3;
        end
        S_RD3: begin
          word_r <= ram_rdata;
          state  <= S_DECIDE;
        end
        S_DECIDE: begin
          res_col    <= place_col;
          res_status <= place_status;
          state      <= S_EMIT;
        end
        S_EMIT: begin
          if (emit_load) begin
            out_data.row          <= 6'(res_row);
            out_data.column       <= 11'(res_col);
            out_data.point_number <= number;
            out_data.status       <= res_status;
            state                 <= go_clear ? S_CLEAR : S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

// File: rtl/lrip_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
`default_nettype none
module lrip_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 2048,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// File: rtl/lrip_cordic.sv
// Iterative CORDIC vectoring unit that turns (x, y) into a binary azimuth angle.
`default_nettype none
module lrip_cordic #(
  parameter int ANGLE_BITS = 16
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  start,
  input  wire logic signed [23:0]    pos_x,
  input  wire logic signed [23:0]    pos_y,
  output logic                       done,
  output logic [ANGLE_BITS-1:0]      angle
);

  localparam int XW = lrip_pkg::CORDIC_XW;
  localparam logic [31:0] ROUND_BIT = 32'(1) << (31 - ANGLE_BITS);

  logic                 busy;
  logic [4:0]           step;
  logic signed [XW-1:0] x;
  logic signed [XW-1:0] y;
  logic [31:0]          z;
  logic signed [XW-1:0] sx;
  logic signed [XW-1:0] sy;
  logic [31:0]          rounded;

  // Inputs scaled by 2^24.
  assign sx = XW'(pos_x) <<< 24;
  assign sy = XW'(pos_y) <<< 24;

  // One micro-rotation per cycle; the left half plane is folded over first.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        step <= 5'd0;
        if (pos_x == 24'sd0 && pos_y == 24'sd0) begin
          z    <= 32'h0;
          done <= 1'b1;
        end else if (pos_x[23]) begin
          x    <= -sx;
          y    <= -sy;
          z    <= 32'h80000000;
          busy <= 1'b1;
        end else begin
          x    <= sx;
          y    <= sy;
          z    <= 32'h0;
          busy <= 1'b1;
        end
      end else if (busy) begin
        if (!y[XW-1]) begin
          x <= x + (y >>> step);
          y <= y - (x >>> step);
          z <= z + lrip_pkg::atan_turn(step);
        end else begin
          x <= x - (y >>> step);
          y <= y + (x >>> step);
          z <= z - lrip_pkg::atan_turn(step);
        end
        step <= step + 5'd1;
        if (step == 5'(lrip_pkg::CORDIC_STEPS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Round to the output angle width; the top bits wrap.
  assign rounded = z + ROUND_BIT;
  assign angle   = rounded[31 -: ANGLE_BITS];

endmodule
`default_nettype wire

// File: rtl/lrip_checker.sv
// Port-level checker for the range image placer and its bind to the top level.
`default_nettype none
module lrip_checker (
  input wire logic                clk,
  input wire logic                rst,
  input wire logic                in_valid,
  input wire logic                in_stall,
  input wire logic                out_valid,
  input wire logic                out_stall,
  input wire lrip_pkg::out_item_t out_data
);

  // A stalled result holds.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result changed");

  // The block works on one item at a time.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("input taken again right after a transfer");

  // A frame start result carries no position and number zero.
  a_cleared_result: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.status == lrip_pkg::ST_CLEARED |->
      out_data.row == 6'd0 && out_data.column == 11'd0 && out_data.point_number == 17'd0)
    else $error("frame start result not zero");

  // Dropped points carry no cell.
  a_dropped_result: assert property (@(posedge clk) disable iff (rst)
    out_valid && (out_data.status == lrip_pkg::ST_MISSING ||
                  out_data.status == lrip_pkg::ST_EXHAUSTED) |->
      out_data.row == 6'd0 && out_data.column == 11'd0)
    else $error("dropped point has a cell");

endmodule

bind lidar_range_image_placer lrip_checker u_lrip_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);
`default_nettype wire
